// File: hdl/assert_macros.svh
// Assertion macros shared by the divider RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/udiv_pkg.sv
// Shared types for the pipelined unsigned divider.
// No dependencies; used by udiv_cell and unsigned_divider_64.
package udiv_pkg;

    // Control that travels with each beat down the cell chain.
    typedef struct packed {
        logic valid;
        logic dz;
    } cell_ctl_t;

endpackage

// File: hdl/udiv_cell.sv
// One restoring-division cell: resolves one quotient bit per beat.
// Depends on udiv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module udiv_cell
    import udiv_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl_in,
    input  logic [W-1:0]     rem_in,
    input  logic [W-1:0]     nq_in,
    input  logic [W-1:0]     den_in,
    output cell_ctl_t        ctl_out,
    output logic [W-1:0]     rem_out,
    output logic [W-1:0]     nq_out,
    output logic [W-1:0]     den_out
);

    cell_ctl_t      ctl_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   rem_next;
    logic [W-1:0]   nq_reg;
    logic [W-1:0]   nq_next;
    logic [W-1:0]   den_reg;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           ge;

    // nq holds unconsumed dividend bits at the top, quotient bits at the bottom
    assign trial = {rem_in, nq_in[W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_comb
    begin
        rem_next = ge ? diff[W-1:0] : trial[W-1:0];
        nq_next  = {nq_in[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;
    assign den_out = den_reg;

    `ASSERT_NEXT(a_beat_advances, ctl_in.valid, ctl_reg.valid)
    `ASSERT_IMPL(a_rem_below_den, ctl_reg.valid && !ctl_reg.dz, rem_reg < den_reg)

endmodule

// File: hdl/unsigned_divider_64.sv
// Top level of the pipelined unsigned divider: chain of udiv_cell plus output register.
// Depends on udiv_pkg, udiv_cell and assert_macros.svh.
//
// Accepts one numerator/denominator beat on every cycle that start is high;
// busy is always low. Each beat passes through DATA_WIDTH cells, one quotient
// bit each, and then through the output register.
// done pulses for one cycle with quotient, remainder and divide_by_zero;
// results come back in issue order and cannot be held off, so the receiver
// must take them when done is high. A zero denominator gives quotient 0,
// remainder equal to the numerator and divide_by_zero set.
`include "assert_macros.svh"

module unsigned_divider_64
    import udiv_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] numerator,
    input  logic [DATA_WIDTH-1:0] denominator,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder,
    output logic                  divide_by_zero
);

    localparam int W = DATA_WIDTH;

    cell_ctl_t      ctl_s [0:W];
    logic [W-1:0]   rem_s [0:W];
    logic [W-1:0]   nq_s  [0:W];
    logic [W-1:0]   den_s [0:W];

    logic           done_reg;
    logic [W-1:0]   quotient_reg;
    logic [W-1:0]   quotient_next;
    logic [W-1:0]   remainder_reg;
    logic           dz_reg;

    assign busy = 1'b0;

    assign ctl_s[0].valid = start;
    assign ctl_s[0].dz    = (denominator == '0);
    assign rem_s[0]       = '0;
    assign nq_s[0]        = numerator;
    assign den_s[0]       = denominator;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        udiv_cell #(
            .W (W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_s[i]),
            .rem_in  (rem_s[i]),
            .nq_in   (nq_s[i]),
            .den_in  (den_s[i]),
            .ctl_out (ctl_s[i+1]),
            .rem_out (rem_s[i+1]),
            .nq_out  (nq_s[i+1]),
            .den_out (den_s[i+1])
        );
    end

    // with a zero divisor every step subtracts nothing: remainder is already
    // the numerator, only the all-ones quotient needs overriding
    assign quotient_next = ctl_s[W].dz ? '0 : nq_s[W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_s[W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg  <= quotient_next;
        remainder_reg <= rem_s[W];
        dz_reg        <= ctl_s[W].dz;
    end

    assign done           = done_reg;
    assign quotient       = quotient_reg;
    assign remainder      = remainder_reg;
    assign divide_by_zero = dz_reg;

    `ASSERT_NEXT(a_last_cell_to_out, ctl_s[W].valid, done)
    `ASSERT_IMPL(a_dz_quot_zero, done && divide_by_zero, quotient == '0)

endmodule
